// ===== sv/swe_pkg.sv =====
`timescale 1ns / 1ps
package swe_pkg;

    localparam logic [31:0] FP_ZERO        = 32'h0000_0000;
    localparam logic [31:0] FP_ONE         = 32'h3F80_0000;
    localparam logic [31:0] FP_TWO         = 32'h4000_0000;
    localparam logic [31:0] FP_THREE       = 32'h4040_0000;
    localparam logic [31:0] FP_FIVE        = 32'h40A0_0000;
    localparam logic [31:0] FP_SIX         = 32'h40C0_0000;
    localparam logic [31:0] FP_EIGHT       = 32'h4100_0000;
    localparam logic [31:0] FP_TWELVE      = 32'h4140_0000;
    localparam logic [31:0] FP_TWENTYFOUR  = 32'h41C0_0000;
    localparam logic [31:0] FP_QNAN        = 32'h7FC0_0000;

    localparam logic [1:0] CMD_REST = 2'd0;
    localparam logic [1:0] CMD_AXIS = 2'd1;
    localparam logic [1:0] CMD_DIAG = 2'd2;

    typedef struct packed {
        logic [31:0] g5;
        logic [31:0] r6;
        logic [31:0] r3;
        logic [31:0] r24;
        logic [31:0] r12;
        logic [31:0] ra;
        logic [31:0] rd;
        logic [31:0] t2c;
    } t_consts;

    // leading zeros of a 48-bit word, 48 when zero
    function automatic logic [5:0] lzc48(input logic [47:0] x);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (x[i]) begin
                n = 6'(47 - i);
            end
        end
        return n;
    endfunction

    // m normalized (msb set), be biased exponent; handles overflow, subnormal, RNE
    function automatic logic [31:0] round_pack(input logic sgn, input logic signed [10:0] be,
                                               input logic [23:0] m, input logic g,
                                               input logic s);
        logic [49:0] w;
        logic [5:0]  rs;
        logic [23:0] mm;
        logic        gg;
        logic        ss;
        logic        inc;
        logic [7:0]  ef;
        logic [30:0] mag;
        w  = '0;
        rs = '0;
        if (be > 11'sd254) begin
            return {sgn, 8'hFF, 23'd0};
        end
        if (be < 11'sd1) begin
            rs = (be < -11'sd25) ? 6'd26 : 6'(11'sd1 - be);
            w  = {m, g, 25'd0} >> rs;
            mm = w[49:26];
            gg = w[25];
            ss = s | (|w[24:0]);
            ef = 8'd0;
        end else begin
            mm = m;
            gg = g;
            ss = s;
            ef = be[7:0];
        end
        inc = gg & (ss | mm[0]);
        mag = {ef, mm[22:0]} + 31'(inc);
        return {sgn, mag};
    endfunction

endpackage

// ===== sv/swe_delay.sv =====
`timescale 1ns / 1ps
module swe_delay #(
    parameter int W = 32,
    parameter int N = 2
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_d [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= i_d;
            for (int i = 1; i < N; i++) begin
                r_d[i] <= r_d[i-1];
            end
        end
    end

    assign o_q = r_d[N-1];

endmodule

// ===== sv/swe_fmul.sv =====
`timescale 1ns / 1ps
module swe_fmul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);

    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    logic [47:0]        r_p;
    logic signed [10:0] r_e;
    logic               r_sgn, r_nan, r_inf, r_zero;
    logic [31:0]        r_y;

    logic [5:0]         lz;
    logic [47:0]        pn;
    logic signed [10:0] be;
    logic [31:0]        n_y;

    always_comb begin
        ea     = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        eb     = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
        ma     = {i_a[30:23] != 8'd0, i_a[22:0]};
        mb     = {i_b[30:23] != 8'd0, i_b[22:0]};
        a_nan  = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan  = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf  = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf  = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        a_zero = (i_a[30:0] == 31'd0);
        b_zero = (i_b[30:0] == 31'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= ma * mb;
            r_e    <= $signed({3'b0, ea}) + $signed({3'b0, eb});
            r_sgn  <= i_a[31] ^ i_b[31];
            r_nan  <= a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
            r_inf  <= a_inf | b_inf;
            r_zero <= a_zero | b_zero;
        end
    end

    always_comb begin
        lz = swe_pkg::lzc48(r_p);
        pn = r_p << lz;
        be = r_e - 11'sd126 - $signed({5'd0, lz});
        if (r_nan) begin
            n_y = swe_pkg::FP_QNAN;
        end else if (r_inf) begin
            n_y = {r_sgn, 8'hFF, 23'd0};
        end else if (r_zero) begin
            n_y = {r_sgn, 31'd0};
        end else begin
            n_y = swe_pkg::round_pack(r_sgn, be, pn[47:24], pn[23], |pn[22:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

// ===== sv/swe_fadd.sv =====
`timescale 1ns / 1ps
module swe_fadd (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_y
);

    logic        swap;
    logic [31:0] big, sml;
    logic [7:0]  e_big, e_sml, d;
    logic [4:0]  dd;
    logic [23:0] m_big, m_sml;
    logic [58:0] x;
    logic [26:0] bal;
    logic [26:0] aext;
    logic        a_nan, b_nan, a_inf, b_inf;

    logic [27:0] r_sum;
    logic [7:0]  r_e;
    logic        r_sgn, r_nan, r_inf, r_inf_sgn, r_zero_sgn;
    logic [31:0] r_y;

    logic [5:0]         lz;
    logic [26:0]        nrm;
    logic signed [10:0] be;
    logic [31:0]        n_y;

    always_comb begin
        swap  = i_b[30:0] > i_a[30:0];
        big   = swap ? i_b : i_a;
        sml   = swap ? i_a : i_b;
        e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        m_big = {big[30:23] != 8'd0, big[22:0]};
        m_sml = {sml[30:23] != 8'd0, sml[22:0]};
        d     = e_big - e_sml;
        dd    = (d > 8'd31) ? 5'd31 : d[4:0];
        x     = {m_sml, 35'd0} >> dd;
        bal   = x[58:32] | {26'd0, |x[31:0]};
        aext  = {m_big, 3'b0};
        a_nan = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum      <= (big[31] ^ sml[31]) ? ({1'b0, aext} - {1'b0, bal})
                                              : ({1'b0, aext} + {1'b0, bal});
            r_e        <= e_big;
            r_sgn      <= big[31];
            r_nan      <= a_nan | b_nan | (a_inf & b_inf & (i_a[31] != i_b[31]));
            r_inf      <= a_inf | b_inf;
            r_inf_sgn  <= a_inf ? i_a[31] : i_b[31];
            r_zero_sgn <= i_a[31] & i_b[31];
        end
    end

    always_comb begin
        lz  = swe_pkg::lzc48({r_sum[26:0], 1'b1, 20'd0});
        nrm = r_sum[26:0] << lz;
        be  = $signed({3'b0, r_e}) - $signed({5'd0, lz});
        if (r_nan) begin
            n_y = swe_pkg::FP_QNAN;
        end else if (r_inf) begin
            n_y = {r_inf_sgn, 8'hFF, 23'd0};
        end else if (r_sum == 28'd0) begin
            n_y = {r_zero_sgn, 31'd0};
        end else if (r_sum[27]) begin
            n_y = swe_pkg::round_pack(r_sgn, $signed({3'b0, r_e}) + 11'sd1, r_sum[27:4],
                                      r_sum[3], |r_sum[2:0]);
        end else begin
            n_y = swe_pkg::round_pack(r_sgn, be, nrm[26:3], nrm[2], nrm[1] | nrm[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

// ===== sv/swe_const.sv =====
`timescale 1ns / 1ps
module swe_const (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [31:0]       i_gravity,
    input  logic [31:0]       i_speed,
    output logic              o_busy,
    output swe_pkg::t_consts  o_consts
);

    typedef enum logic [3:0] {
        ST_B6, ST_B3, ST_B24, ST_B12, ST_EE, ST_G5, ST_EE2, ST_EE8,
        ST_R6, ST_R3, ST_R24, ST_R12, ST_RA, ST_RD, ST_T2C, ST_DONE
    } t_step;

    t_step       r_step;
    logic [4:0]  r_cnt;
    logic [31:0] r_b6, r_b3, r_b24, r_b12, r_ee, r_ee2, r_ee8;
    swe_pkg::t_consts r_consts;

    logic [23:0]        r_dmx;
    logic [23:0]        r_rem;
    logic [26:0]        r_q;
    logic signed [10:0] r_dexp;
    logic               r_dsgn;
    logic               r_dsp;
    logic [31:0]        r_dspv;

    logic [31:0] mul_a, mul_b, mul_y, div_x, div_y, res;
    logic        is_div, done_op;

    logic [23:0]        mx;
    logic [5:0]         xlz;
    logic signed [10:0] xexp;
    logic [24:0]        t;
    logic               ge;
    logic [23:0]        n_rem;
    logic [26:0]        sig;
    logic signed [10:0] rbe;

    swe_fmul u_fmul (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_y   (mul_y)
    );

    always_comb begin
        mul_a = swe_pkg::FP_ZERO;
        mul_b = swe_pkg::FP_ZERO;
        div_x = swe_pkg::FP_ZERO;
        is_div = 1'b0;
        unique case (r_step)
            ST_B6:   begin mul_a = i_speed;        mul_b = swe_pkg::FP_SIX;        end
            ST_B3:   begin mul_a = i_speed;        mul_b = swe_pkg::FP_THREE;      end
            ST_B24:  begin mul_a = i_speed;        mul_b = swe_pkg::FP_TWENTYFOUR; end
            ST_B12:  begin mul_a = i_speed;        mul_b = swe_pkg::FP_TWELVE;     end
            ST_EE:   begin mul_a = i_speed;        mul_b = i_speed;                end
            ST_G5:   begin mul_a = swe_pkg::FP_FIVE; mul_b = i_gravity;            end
            ST_EE2:  begin mul_a = r_ee;           mul_b = swe_pkg::FP_TWO;        end
            ST_EE8:  begin mul_a = r_ee;           mul_b = swe_pkg::FP_EIGHT;      end
            ST_R6:   begin div_x = r_b6;  is_div = 1'b1; end
            ST_R3:   begin div_x = r_b3;  is_div = 1'b1; end
            ST_R24:  begin div_x = r_b24; is_div = 1'b1; end
            ST_R12:  begin div_x = r_b12; is_div = 1'b1; end
            ST_RA:   begin div_x = r_ee2; is_div = 1'b1; end
            ST_RD:   begin div_x = r_ee8; is_div = 1'b1; end
            ST_T2C:  begin mul_a = swe_pkg::FP_TWO; mul_b = r_consts.r3;       end
            ST_DONE: begin end
        endcase
        done_op = is_div ? (r_cnt == 5'd28) : (r_cnt == 5'd2);
    end

    // reciprocal: unpack, then one quotient bit of 2^49 / mantissa per cycle
    always_comb begin
        mx   = {div_x[30:23] != 8'd0, div_x[22:0]};
        xlz  = swe_pkg::lzc48({mx, 1'b1, 23'd0});
        xexp = ((div_x[30:23] == 8'd0) ? -11'sd126 : ($signed({3'b0, div_x[30:23]}) - 11'sd127))
               - $signed({5'd0, xlz});
        t     = {r_rem, 1'b0};
        ge    = t >= {1'b0, r_dmx};
        n_rem = ge ? 24'(t - {1'b0, r_dmx}) : t[23:0];
        if (r_q[26]) begin
            sig = r_q;
            rbe = 11'sd127 - r_dexp;
        end else begin
            sig = {r_q[25:0], 1'b0};
            rbe = 11'sd126 - r_dexp;
        end
        div_y = r_dsp ? r_dspv
                      : swe_pkg::round_pack(r_dsgn, rbe, sig[26:3], sig[2],
                                            sig[1] | sig[0] | (r_rem != 24'd0));
        res = is_div ? div_y : mul_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_step <= ST_B6;
            r_cnt  <= '0;
        end else if (r_step != ST_DONE) begin
            if (done_op) begin
                r_step <= t_step'(r_step + 4'd1);
                r_cnt  <= '0;
                unique case (r_step)
                    ST_B6:   r_b6         <= res;
                    ST_B3:   r_b3         <= res;
                    ST_B24:  r_b24        <= res;
                    ST_B12:  r_b12        <= res;
                    ST_EE:   r_ee         <= res;
                    ST_G5:   r_consts.g5  <= res;
                    ST_EE2:  r_ee2        <= res;
                    ST_EE8:  r_ee8        <= res;
                    ST_R6:   r_consts.r6  <= res;
                    ST_R3:   r_consts.r3  <= res;
                    ST_R24:  r_consts.r24 <= res;
                    ST_R12:  r_consts.r12 <= res;
                    ST_RA:   r_consts.ra  <= res;
                    ST_RD:   r_consts.rd  <= res;
                    ST_T2C:  r_consts.t2c <= res;
                    ST_DONE: begin end
                endcase
            end else begin
                r_cnt <= r_cnt + 5'd1;
            end
            if (is_div) begin
                if (r_cnt == 5'd0) begin
                    r_dmx  <= mx << xlz;
                    r_dexp <= xexp;
                    r_dsgn <= div_x[31];
                    r_rem  <= 24'h40_0000;
                    r_q    <= '0;
                    if (div_x[30:23] == 8'hFF && div_x[22:0] != 23'd0) begin
                        r_dsp  <= 1'b1;
                        r_dspv <= swe_pkg::FP_QNAN;
                    end else if (div_x[30:23] == 8'hFF) begin
                        r_dsp  <= 1'b1;
                        r_dspv <= {div_x[31], 31'd0};
                    end else if (div_x[30:0] == 31'd0) begin
                        r_dsp  <= 1'b1;
                        r_dspv <= {div_x[31], 8'hFF, 23'd0};
                    end else begin
                        r_dsp  <= 1'b0;
                        r_dspv <= swe_pkg::FP_ZERO;
                    end
                end else if (r_cnt <= 5'd27) begin
                    r_rem <= n_rem;
                    r_q   <= {r_q[25:0], ge};
                end
            end
        end
    end

    assign o_busy   = (r_step != ST_DONE);
    assign o_consts = r_consts;

endmodule

// ===== sv/shallow_water_lbm_equilibrium.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake               Payload
// cfg       in   psel/penable/pwrite     paddr 4*i: gravity, lattice_speed, dir_x, dir_y
// s_axis    in   tvalid/tready           tdata {vel_y, vel_x, height}, tuser cmd, tlast
// m_axis    out  tvalid/tready           tdata equilibrium, tlast
//
// One request per cycle while s_axis_tready is high; the result passes nine float ops
// of two stages each, the first capturing at the accept edge, plus the output register.
// A stalled m_axis holds every stage; nothing is dropped or repeated.
// After reset and after every register write the constant unit computes the scaled
// reciprocals of e (shared multiplier, 27-step divider); s_axis_tready is low meanwhile.
// Reset is synchronous, active low.
module shallow_water_lbm_equilibrium (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // height [31:0], vel_x [63:32], vel_y [95:64]
    input  logic [1:0]  s_axis_tuser,   // cmd
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // equilibrium
    output logic        m_axis_tlast
);

    localparam logic [1:0] REG_GRAVITY = 2'd0;
    localparam logic [1:0] REG_SPEED   = 2'd1;
    localparam logic [1:0] REG_DIR_X   = 2'd2;
    localparam logic [1:0] REG_DIR_Y   = 2'd3;

    logic [31:0] r_gravity, r_speed, r_dir_x, r_dir_y;
    logic        cfg_wr, busy, en, acc;
    swe_pkg::t_consts k;

    logic        r_vld  [18];
    logic [1:0]  r_cmd  [18];
    logic        r_last [18];
    logic [31:0] r_h    [16];

    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        r_out_last;

    logic [31:0] h, u, v;
    logic [31:0] w_xu, w_yv, w_hg, w_uu, w_vv, w_a5;
    logic [31:0] w_q, w_s, w_xx, w_c2, w_yy, w_t1m, w_t1r;
    logic [31:0] w_t4, w_t2, w_c, w_t2r, w_mr;
    logic [31:0] w_a, w_sum1, w_mr2;
    logic [31:0] w_a2, w_fr, w_t3, w_sum2, w_sum3, w_fm;
    logic [31:0] d_yv, d_xx, d_t1m, d_yy, d_sum1, d_t4, d_fr;
    logic [31:0] r1_2, r1_4, r2_4, r3_10;
    logic [31:0] res, n_out;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= swe_pkg::FP_ONE;
            r_speed   <= swe_pkg::FP_ONE;
            r_dir_x   <= swe_pkg::FP_ONE;
            r_dir_y   <= swe_pkg::FP_ZERO;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_GRAVITY: r_gravity <= pwdata;
                REG_SPEED:   r_speed   <= pwdata;
                REG_DIR_X:   r_dir_x   <= pwdata;
                REG_DIR_Y:   r_dir_y   <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_GRAVITY: prdata = r_gravity;
            REG_SPEED:   prdata = r_speed;
            REG_DIR_X:   prdata = r_dir_x;
            REG_DIR_Y:   prdata = r_dir_y;
        endcase
    end

    swe_const u_const (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cfg_wr),
        .i_gravity (r_gravity),
        .i_speed   (r_speed),
        .o_busy    (busy),
        .o_consts  (k)
    );

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en && !busy;
    assign acc           = s_axis_tvalid && s_axis_tready;

    assign h = s_axis_tdata[31:0];
    assign u = s_axis_tdata[63:32];
    assign v = s_axis_tdata[95:64];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 18; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= acc;
            for (int i = 1; i < 18; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd[0]  <= s_axis_tuser;
            r_last[0] <= s_axis_tlast;
            r_h[0]    <= h;
            for (int i = 1; i < 18; i++) begin
                r_cmd[i]  <= r_cmd[i-1];
                r_last[i] <= r_last[i-1];
            end
            for (int i = 1; i < 16; i++) begin
                r_h[i] <= r_h[i-1];
            end
        end
    end

    assign r1_2  = (r_cmd[1] == swe_pkg::CMD_DIAG) ? k.r24 : k.r6;
    assign r1_4  = (r_cmd[3] == swe_pkg::CMD_DIAG) ? k.r24 : k.r6;
    assign r2_4  = (r_cmd[3] == swe_pkg::CMD_DIAG) ? k.r12 : k.r3;
    assign r3_10 = (r_cmd[9] == swe_pkg::CMD_DIAG) ? k.rd  : k.ra;

    // level 1
    swe_fmul u_xu (.i_clk(i_clk), .i_en(en), .i_a(r_dir_x), .i_b(u), .o_y(w_xu));
    swe_fmul u_yv (.i_clk(i_clk), .i_en(en), .i_a(r_dir_y), .i_b(v), .o_y(w_yv));
    swe_fmul u_hg (.i_clk(i_clk), .i_en(en), .i_a(h), .i_b(r_gravity), .o_y(w_hg));
    swe_fmul u_uu (.i_clk(i_clk), .i_en(en), .i_a(u), .i_b(u), .o_y(w_uu));
    swe_fmul u_vv (.i_clk(i_clk), .i_en(en), .i_a(v), .i_b(v), .o_y(w_vv));
    swe_fmul u_a5 (.i_clk(i_clk), .i_en(en), .i_a(k.g5), .i_b(h), .o_y(w_a5));

    // level 2
    swe_fadd u_q   (.i_clk(i_clk), .i_en(en), .i_a(w_uu), .i_b(w_vv), .o_y(w_q));
    swe_fadd u_s   (.i_clk(i_clk), .i_en(en), .i_a(w_xu), .i_b(w_yv), .o_y(w_s));
    swe_fmul u_xx  (.i_clk(i_clk), .i_en(en), .i_a(w_xu), .i_b(w_xu), .o_y(w_xx));
    swe_fmul u_c2  (.i_clk(i_clk), .i_en(en), .i_a(swe_pkg::FP_TWO), .i_b(w_xu), .o_y(w_c2));
    swe_fmul u_yy  (.i_clk(i_clk), .i_en(en), .i_a(w_yv), .i_b(w_yv), .o_y(w_yy));
    swe_fmul u_t1m (.i_clk(i_clk), .i_en(en), .i_a(w_hg), .i_b(r1_2), .o_y(w_t1m));
    swe_fmul u_t1r (.i_clk(i_clk), .i_en(en), .i_a(w_a5), .i_b(k.r6), .o_y(w_t1r));
    swe_delay #(.W(32), .N(2)) u_d_yv (.i_clk(i_clk), .i_en(en), .i_d(w_yv), .o_q(d_yv));

    // level 3
    swe_fmul u_t4  (.i_clk(i_clk), .i_en(en), .i_a(w_q), .i_b(r1_4), .o_y(w_t4));
    swe_fmul u_t2  (.i_clk(i_clk), .i_en(en), .i_a(w_s), .i_b(r2_4), .o_y(w_t2));
    swe_fmul u_c   (.i_clk(i_clk), .i_en(en), .i_a(w_c2), .i_b(d_yv), .o_y(w_c));
    swe_fmul u_t2r (.i_clk(i_clk), .i_en(en), .i_a(k.t2c), .i_b(w_q), .o_y(w_t2r));
    swe_fadd u_mr  (.i_clk(i_clk), .i_en(en), .i_a(swe_pkg::FP_ONE),
                    .i_b({~w_t1r[31], w_t1r[30:0]}), .o_y(w_mr));
    swe_delay #(.W(32), .N(2)) u_d_xx  (.i_clk(i_clk), .i_en(en), .i_d(w_xx), .o_q(d_xx));
    swe_delay #(.W(32), .N(2)) u_d_t1m (.i_clk(i_clk), .i_en(en), .i_d(w_t1m), .o_q(d_t1m));
    swe_delay #(.W(32), .N(4)) u_d_yy  (.i_clk(i_clk), .i_en(en), .i_d(w_yy), .o_q(d_yy));

    // level 4
    swe_fadd u_a    (.i_clk(i_clk), .i_en(en), .i_a(d_xx), .i_b(w_c), .o_y(w_a));
    swe_fadd u_sum1 (.i_clk(i_clk), .i_en(en), .i_a(d_t1m), .i_b(w_t2), .o_y(w_sum1));
    swe_fadd u_mr2  (.i_clk(i_clk), .i_en(en), .i_a(w_mr),
                     .i_b({~w_t2r[31], w_t2r[30:0]}), .o_y(w_mr2));
    swe_delay #(.W(32), .N(8)) u_d_t4 (.i_clk(i_clk), .i_en(en), .i_d(w_t4), .o_q(d_t4));

    // level 5
    swe_fadd u_a2 (.i_clk(i_clk), .i_en(en), .i_a(w_a), .i_b(d_yy), .o_y(w_a2));
    swe_fmul u_fr (.i_clk(i_clk), .i_en(en), .i_a(r_h[7]), .i_b(w_mr2), .o_y(w_fr));
    swe_delay #(.W(32), .N(4)) u_d_sum1 (.i_clk(i_clk), .i_en(en), .i_d(w_sum1), .o_q(d_sum1));
    swe_delay #(.W(32), .N(8)) u_d_fr   (.i_clk(i_clk), .i_en(en), .i_d(w_fr), .o_q(d_fr));

    // levels 6 to 9
    swe_fmul u_t3   (.i_clk(i_clk), .i_en(en), .i_a(w_a2), .i_b(r3_10), .o_y(w_t3));
    swe_fadd u_sum2 (.i_clk(i_clk), .i_en(en), .i_a(d_sum1), .i_b(w_t3), .o_y(w_sum2));
    swe_fadd u_sum3 (.i_clk(i_clk), .i_en(en), .i_a(w_sum2),
                     .i_b({~d_t4[31], d_t4[30:0]}), .o_y(w_sum3));
    swe_fmul u_fm   (.i_clk(i_clk), .i_en(en), .i_a(w_sum3), .i_b(r_h[15]), .o_y(w_fm));

    always_comb begin
        unique case (r_cmd[17])
            swe_pkg::CMD_REST: res = d_fr;
            swe_pkg::CMD_AXIS: res = w_fm;
            swe_pkg::CMD_DIAG: res = w_fm;
            default:           res = swe_pkg::FP_ZERO;
        endcase
        if (res[30:23] == 8'hFF && res[22:0] != 23'd0) begin
            n_out = swe_pkg::FP_QNAN;
        end else begin
            n_out = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[17];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out;
            r_out_last <= r_last[17];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // height [31:0], vel_x [63:32], vel_y [95:64]
    logic [1:0]  s_axis_tuser;   // cmd
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // equilibrium
    logic        m_axis_tlast;

    localparam logic [3:0] REG_GRAVITY = 4'd0;
    localparam logic [3:0] REG_SPEED   = 4'd4;
    localparam logic [3:0] REG_DIR_X   = 4'd8;
    localparam logic [3:0] REG_DIR_Y   = 4'd12;
    localparam logic [1:0] CMD_NONE    = 2'd3;
    localparam logic [31:0] FP_INF     = 32'h7F80_0000;
    localparam logic [31:0] FP_MAX     = 32'h7F7F_FFFF;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [31:0] value;
        logic        last;
    } t_cell_result;

    t_cell_result eq_q[$];
    logic [31:0] gravity_r, speed_r, dir_x_r, dir_y_r;
    int errors;
    int cycles;
    bit idle_en;
    int hold_req;
    int hold_cnt;
    int rx_gap;

    shallow_water_lbm_equilibrium u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- single-precision arithmetic via exact doubles ----------------
    function automatic real f32_to_real(logic [31:0] f);
        real r;
        if (f[30:23] == 8'hFF) begin
            return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'd0});
        end
        if (f[30:23] == 8'd0) begin
            r = real'(f[22:0]) * (2.0 ** (-149));
            return f[31] ? -r : r;
        end
        return $bitstoreal({f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0});
    endfunction

    function automatic logic [31:0] real_to_f32(real x);
        logic [63:0] b;
        logic [52:0] m;
        logic [52:0] kept;
        logic [30:0] mag;
        logic        g;
        logic        st;
        int          be;
        int          sh;
        b = $realtobits(x);
        if (b[62:52] == 11'h7FF) begin
            return (b[51:0] != 0) ? swe_pkg::FP_QNAN : {b[63], FP_INF[30:0]};
        end
        if (b[62:52] == 11'd0) begin
            return {b[63], 31'd0};
        end
        m  = {1'b1, b[51:0]};
        be = int'(b[62:52]) - 1023 + 127;
        if (be > 254) begin
            return {b[63], FP_INF[30:0]};
        end
        if (be >= 1) begin
            g   = m[28];
            st  = |m[27:0];
            mag = {be[7:0], m[51:29]} + 31'(g & (st | m[29]));
            return {b[63], mag};
        end
        sh = 30 - be;
        if (sh > 53) begin
            return {b[63], 31'd0};
        end
        kept = m >> sh;
        g    = m[sh-1];
        st   = |(m & ((53'd1 << (sh - 1)) - 53'd1));
        mag  = kept[30:0] + 31'(g & (st | kept[0]));
        return {b[63], mag};
    endfunction

    function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
        return real_to_f32(f32_to_real(a) * f32_to_real(b));
    endfunction

    function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
        return real_to_f32(f32_to_real(a) + f32_to_real(b));
    endfunction

    function automatic logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
        return real_to_f32(f32_to_real(a) - f32_to_real(b));
    endfunction

    function automatic logic [31:0] frecip(logic [31:0] d);
        if (d[30:0] == 31'd0) begin
            return {d[31], FP_INF[30:0]};
        end
        return real_to_f32(1.0 / f32_to_real(d));
    endfunction

    // ---------------- equilibrium predictor ----------------
    function automatic logic [31:0] rest_term(logic [31:0] h, logic [31:0] u, logic [31:0] v);
        logic [31:0] a, b, t1, t2, q, m;
        a  = fmul(fmul(swe_pkg::FP_FIVE, gravity_r), h);
        t1 = fmul(a, frecip(fmul(speed_r, swe_pkg::FP_SIX)));
        t2 = fmul(swe_pkg::FP_TWO, frecip(fmul(speed_r, swe_pkg::FP_THREE)));
        a  = fmul(u, u);
        b  = fmul(v, v);
        q  = fadd(a, b);
        t2 = fmul(t2, q);
        m  = fsub(fsub(swe_pkg::FP_ONE, t1), t2);
        return fmul(h, m);
    endfunction

    function automatic logic [31:0] moving_term(logic [31:0] h, logic [31:0] u, logic [31:0] v,
                                                logic [31:0] k1, logic [31:0] k2,
                                                logic [31:0] k3);
        logic [31:0] xu, yv, a, b, c, r, t1, t2, t3, t4, s, sum;
        xu = fmul(dir_x_r, u);
        yv = fmul(dir_y_r, v);
        a  = fmul(h, gravity_r);
        r  = frecip(fmul(speed_r, k1));
        t1 = fmul(a, r);
        a  = fadd(fmul(u, u), fmul(v, v));
        t4 = fmul(a, r);
        r  = frecip(fmul(speed_r, k2));
        s  = fadd(xu, yv);
        t2 = fmul(s, r);
        b  = fmul(fmul(speed_r, speed_r), k3);
        r  = frecip(b);
        a  = fmul(xu, xu);
        c  = fmul(fmul(swe_pkg::FP_TWO, xu), yv);
        a  = fadd(a, c);
        c  = fmul(yv, yv);
        a  = fadd(a, c);
        t3 = fmul(a, r);
        sum = fsub(fadd(fadd(t1, t2), t3), t4);
        return fmul(sum, h);
    endfunction

    function automatic logic [31:0] predict_equilibrium(logic [1:0] cmd, logic [31:0] h,
                                                        logic [31:0] u, logic [31:0] v);
        logic [31:0] res;
        case (cmd)
            swe_pkg::CMD_REST: res = rest_term(h, u, v);
            swe_pkg::CMD_AXIS: res = moving_term(h, u, v, swe_pkg::FP_SIX, swe_pkg::FP_THREE,
                                                 swe_pkg::FP_TWO);
            swe_pkg::CMD_DIAG: res = moving_term(h, u, v, swe_pkg::FP_TWENTYFOUR,
                                                 swe_pkg::FP_TWELVE, swe_pkg::FP_EIGHT);
            default:           res = swe_pkg::FP_ZERO;
        endcase
        if (res[30:23] == 8'hFF && res[22:0] != 23'd0) begin
            res = swe_pkg::FP_QNAN;
        end
        return res;
    endfunction

    // ---------------- reporting and checking ----------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH @%0t %s: got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_cell_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (eq_q.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, 32'd0);
            end else begin
                want = eq_q.pop_front();
                if (m_axis_tdata !== want.value) begin
                    report_mismatch("equilibrium", m_axis_tdata, want.value);
                end
                if (m_axis_tlast !== want.last) begin
                    report_mismatch("tlast", 32'(m_axis_tlast), 32'(want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result sink with random stalls and a long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= 0;
            rx_gap        <= 0;
        end else if (hold_req != 0) begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= hold_req;
            hold_req = 0;
        end else if (hold_cnt != 0) begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= hold_cnt - 1;
        end else if (rx_gap != 0) begin
            m_axis_tready <= 1'b0;
            rx_gap        <= rx_gap - 1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            rx_gap        <= $urandom_range(0, 13);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------- drivers ----------------
    task automatic send_cell(logic [1:0] cmd, logic [31:0] h, logic [31:0] u, logic [31:0] v,
                             logic last);
        t_cell_result want;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, u, h};
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        want.value = predict_equilibrium(cmd, h, u, v);
        want.last  = last;
        eq_q.push_back(want);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (eq_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [3:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            REG_GRAVITY: gravity_r = data;
            REG_SPEED:   speed_r   = data;
            REG_DIR_X:   dir_x_r   = data;
            default:     dir_y_r   = data;
        endcase
    endtask

    task automatic set_lattice(logic [31:0] g, logic [31:0] e, logic [31:0] dx, logic [31:0] dy);
        stop_sending();
        wait_drained();
        write_reg(REG_GRAVITY, g);
        write_reg(REG_SPEED, e);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
    endtask

    function automatic logic [31:0] rand_fp();
        logic [31:0] specials[8] = '{32'h0, 32'h8000_0000, FP_INF, 32'hFF80_0000,
                                     32'h7FC0_0001, FP_MAX, 32'h0000_0001, swe_pkg::FP_ONE};
        case ($urandom_range(0, 9))
            0:       return specials[$urandom_range(0, 7)];
            1:       return $urandom;
            2:       return {1'($urandom), 8'd0, 23'($urandom)};
            default: return {1'($urandom), 8'($urandom_range(118, 134)), 23'($urandom)};
        endcase
    endfunction

    task automatic send_random(int n);
        logic [1:0] cmd;
        repeat (n) begin
            cmd = ($urandom_range(0, 15) == 0) ? CMD_NONE : 2'($urandom_range(0, 2));
            send_cell(cmd, rand_fp(), rand_fp(), rand_fp(), 1'($urandom));
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        logic [31:0] tenth;
        tenth = 32'h3DCC_CCCD;
        send_cell(swe_pkg::CMD_REST, swe_pkg::FP_ONE, tenth, swe_pkg::FP_ZERO, 1'b0);
        send_cell(swe_pkg::CMD_AXIS, swe_pkg::FP_ONE, tenth, tenth, 1'b0);
        send_cell(swe_pkg::CMD_DIAG, swe_pkg::FP_TWO, tenth, 32'hBDCC_CCCD, 1'b0);
        send_cell(CMD_NONE, swe_pkg::FP_ONE, tenth, tenth, 1'b1);
        send_cell(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        for (int c = 0; c < 3; c++) begin
            send_cell(2'(c), swe_pkg::FP_ZERO, swe_pkg::FP_ZERO, swe_pkg::FP_ZERO, 1'b0);
            send_cell(2'(c), 32'h8000_0000, swe_pkg::FP_ONE, swe_pkg::FP_ONE, 1'b1);
            send_cell(2'(c), FP_INF, tenth, swe_pkg::FP_ZERO, 1'b0);
            send_cell(2'(c), swe_pkg::FP_ONE, 32'h7FC0_0000, swe_pkg::FP_ZERO, 1'b0);
            send_cell(2'(c), FP_MAX, FP_MAX, FP_MAX, 1'b1);
            send_cell(2'(c), 32'h0000_0001, 32'h0080_0000, 32'h807F_FFFF, 1'b0);
        end
    endtask

    task automatic test_config_sweep();
        logic [31:0] e_list[8] = '{swe_pkg::FP_ONE, swe_pkg::FP_ZERO, 32'h8000_0000, FP_INF,
                                   32'h0000_0001, FP_MAX, 32'h4059_999A, 32'hFFFF_FFFF};
        logic [31:0] g_list[8] = '{32'h411C_F5C3, swe_pkg::FP_ONE, 32'h7FC0_0000,
                                   swe_pkg::FP_ZERO, FP_MAX, 32'hFFFF_FFFF, 32'h3F00_0000,
                                   32'h0000_0001};
        logic [31:0] d_list[8] = '{swe_pkg::FP_ONE, swe_pkg::FP_ZERO, 32'hBF80_0000,
                                   32'h3F35_04F3, FP_INF, 32'h0000_0000, 32'hFFFF_FFFF,
                                   32'h8000_0000};
        for (int k = 0; k < 8; k++) begin
            set_lattice(g_list[k], e_list[k], d_list[k], d_list[(k + 3) % 8]);
            send_random(150);
        end
        set_lattice($urandom, $urandom, $urandom, $urandom);
        send_random(100);
        set_lattice(32'h411C_F5C3, swe_pkg::FP_ONE, swe_pkg::FP_ONE, swe_pkg::FP_ONE);
    endtask

    task automatic test_backpressure();
        hold_req = 400;
        send_random(80);
    endtask

    task automatic test_sender_pause();
        send_random(40);
        stop_sending();
        wait_drained();
        send_random(40);
    endtask

    task automatic test_streaming();
        idle_en = 1'b0;
        send_random(370);
        stop_sending();
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        errors = 0;
        cycles = 0;
        idle_en = 1'b1;
        hold_req = 0;
        gravity_r = swe_pkg::FP_ONE;
        speed_r = swe_pkg::FP_ONE;
        dir_x_r = swe_pkg::FP_ONE;
        dir_y_r = swe_pkg::FP_ZERO;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_sweep();
        test_backpressure();
        test_sender_pause();
        test_streaming();

        while (eq_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
